### rtl/core/ffha_pkg.sv
// ffha_pkg: constants, types and codes shared by the allocator core.
// No dependencies.
package ffha_pkg;

  localparam int PageBytes    = 4096;
  localparam int MaxExtents   = 64;
  localparam int HeapPagesMax = 256;
  localparam int GrainBytes   = 16;
  localparam int HdrDepth     = HeapPagesMax * (PageBytes / GrainBytes);
  localparam int HeapBytes    = HeapPagesMax * PageBytes;

  localparam int OffW  = $clog2(HeapBytes);
  localparam int SizeW = OffW + 1;
  localparam int ExtAW = $clog2(MaxExtents);
  localparam int CntW  = ExtAW + 1;
  localparam int HdrAW = $clog2(HdrDepth);
  localparam int PageW = $clog2(HeapPagesMax) + 1;
  localparam int GrW   = $clog2(GrainBytes);
  localparam int PgShW = $clog2(PageBytes);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [OffW-1:0]  start;
    logic [SizeW-1:0] size;
  } extent_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HDR_RD, S_HDR_CHK,
    S_SCAN_RD, S_SCAN_CHK, S_LAST_RD, S_LAST_CHK,
    S_GROW, S_CARVE,
    S_FSCAN_RD, S_FSCAN_CHK, S_FRIGHT_RD, S_FRIGHT_CHK, S_FDECIDE,
    S_SHL_RD, S_SHL_WR, S_SHR_RD, S_SHR_WR,
    S_FIN_WR, S_DONE
  } state_t;

endpackage

### rtl/core/ffha_ram.sv
// ffha_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
module ffha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/core/first_fit_heap_allocator.sv
// first_fit_heap_allocator: top level, sequencer over extent table and header RAMs.
// Depends on ffha_pkg and ffha_ram.
//
//  channel | signals                                   | contents
//  s_axis  | s_tvalid s_tready s_tdata                 | op, req_bytes, free_addr
//  m_axis  | m_tvalid m_tready m_tdata                 | result_addr, status
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | heap_base(0), page_limit(1)
//
// One item at a time: a scan reads extents in turn and a shift moves them one by one
// through the one port of the extent table; a scan and the shift after it cover each
// extent at most once. After reset a clearing pass over all HdrDepth (65536) entries
// zeroes the header RAM; no item is taken meanwhile. The result sits in an output
// register; input is refused until it is transferred.
module first_fit_heap_allocator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [87:0]  s_tdata,   // [0] op, [21:1] req_bytes, [85:22] free_addr
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,   // [63:0] result_addr, [65:64] status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  localparam int OffW  = ffha_pkg::OffW;
  localparam int SizeW = ffha_pkg::SizeW;
  localparam int ExtAW = ffha_pkg::ExtAW;
  localparam int CntW  = ffha_pkg::CntW;
  localparam int HdrAW = ffha_pkg::HdrAW;
  localparam int PageW = ffha_pkg::PageW;
  localparam int GrW   = ffha_pkg::GrW;
  localparam int PgShW = ffha_pkg::PgShW;

  ffha_pkg::state_t state, state_next;

  logic [63:0]      heap_base;
  logic [8:0]       page_limit;
  logic [CntW-1:0]  ext_count;
  logic [PageW-1:0] pages_held;

  // per-request working registers
  logic             op;
  logic [SizeW:0]   bytes;     // rounded request, may exceed the largest heap
  logic [OffW-1:0]  off;
  logic [SizeW-1:0] fsize;
  logic [CntW-1:0]  idx;       // scan index / target entry
  logic [CntW-1:0]  sh;        // shift address pointer
  logic             bad_range;
  ffha_pkg::extent_t cur, lft;
  logic             lft_valid;
  logic             grew_merge;
  logic             ext_wr;    // final write of cur into the extent table
  logic [1:0]       res_status;
  logic [63:0]      res_addr;
  logic [HdrAW-1:0] clr_addr;

  // extent RAM port
  logic              e_we;
  logic [ExtAW-1:0]  e_addr;
  ffha_pkg::extent_t e_wdata, e_rdata;
  // header RAM port
  logic              h_we;
  logic [HdrAW-1:0]  h_addr;
  logic [SizeW-1:0]  h_wdata, h_rdata;

  ffha_ram #(.Width(OffW + SizeW), .Depth(ffha_pkg::MaxExtents)) u_ext (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));
  ffha_ram #(.Width(SizeW), .Depth(ffha_pkg::HdrDepth)) u_hdr (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));

  assign s_tready  = (state == ffha_pkg::S_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {6'd0, res_status, res_addr};

  // derived combinational values
  logic [SizeW:0]   req_round;
  logic [63:0]      foff64;
  logic [8:0]       lim;
  logic [PageW:0]   grow_n;
  logic [PageW+1:0] grow_sum;
  logic             grow_nomem;
  logic [SizeW-1:0] grow_bytes;
  logic [OffW:0]    nstart;
  logic [SizeW:0]   cur_end;
  logic [SizeW:0]   lft_end;
  logic [SizeW:0]   blk_end;
  logic [SizeW:0]   carve_end;
  logic [OffW-1:0]  carve_off;
  logic [SizeW-1:0] cur_left;
  logic             carve_rm;
  logic             fit;
  logic             f_left, f_right;
  logic             ext_full;

  assign req_round  = (SizeW+1)'(s_tdata[21:1]) + (SizeW+1)'(32) &
                      ~(SizeW+1)'(ffha_pkg::GrainBytes - 1);
  assign foff64     = s_tdata[85:22] - heap_base - 64'd8;
  assign lim        = (page_limit > 9'(ffha_pkg::HeapPagesMax)) ?
                      9'(ffha_pkg::HeapPagesMax) : page_limit;
  assign grow_n     = (PageW+1)'(bytes >> PgShW) + (PageW+1)'(2);
  assign grow_sum   = (PageW+2)'(pages_held) + (PageW+2)'(grow_n);
  assign grow_nomem = grow_sum > (PageW+2)'(lim);
  assign grow_bytes = SizeW'(grow_n[PageW-1:0]) << PgShW;
  assign nstart     = (OffW+1)'(pages_held) << PgShW;
  assign cur_end    = (SizeW+1)'(e_rdata.start) + (SizeW+1)'(e_rdata.size);
  assign lft_end    = (SizeW+1)'(lft.start) + (SizeW+1)'(lft.size);
  assign blk_end    = (SizeW+1)'(off) + (SizeW+1)'(fsize);
  assign carve_end  = (SizeW+1)'(cur.start) + (SizeW+1)'(cur.size) - bytes;
  assign carve_off  = carve_end[OffW-1:0];
  assign cur_left   = cur.size - bytes[SizeW-1:0];
  assign carve_rm   = cur_left < SizeW'(ffha_pkg::GrainBytes);
  assign fit        = (SizeW+1)'(e_rdata.size) >= bytes;
  assign f_left     = lft_valid && (lft_end == (SizeW+1)'(off));
  assign f_right    = (idx < ext_count) && (blk_end == (SizeW+1)'(cur.start));
  assign ext_full   = ext_count >= CntW'(ffha_pkg::MaxExtents);

  always_comb begin
    state_next = state;
    case (state)
      ffha_pkg::S_CLEAR: if (clr_addr == HdrAW'(ffha_pkg::HdrDepth - 1))
                           state_next = ffha_pkg::S_IDLE;
      ffha_pkg::S_IDLE: if (s_tvalid && s_tready) begin
        if (s_tdata[0] == ffha_pkg::OP_ALLOC) state_next = ffha_pkg::S_SCAN_RD;
        else if (s_tdata[85:22] == 64'd0) state_next = ffha_pkg::S_DONE;
        else state_next = ffha_pkg::S_HDR_RD;
      end
      ffha_pkg::S_HDR_RD: state_next = bad_range ? ffha_pkg::S_DONE : ffha_pkg::S_HDR_CHK;
      ffha_pkg::S_HDR_CHK: state_next = (h_rdata == '0) ? ffha_pkg::S_DONE :
                                        ffha_pkg::S_FSCAN_RD;
      ffha_pkg::S_SCAN_RD: state_next = (idx >= ext_count) ? ffha_pkg::S_LAST_RD :
                                        ffha_pkg::S_SCAN_CHK;
      ffha_pkg::S_SCAN_CHK: state_next = fit ? ffha_pkg::S_CARVE : ffha_pkg::S_SCAN_RD;
      ffha_pkg::S_LAST_RD: state_next = ffha_pkg::S_LAST_CHK;
      ffha_pkg::S_LAST_CHK: state_next = ffha_pkg::S_GROW;
      ffha_pkg::S_GROW: state_next = (grow_nomem || (!grew_merge && ext_full)) ?
                                     ffha_pkg::S_DONE : ffha_pkg::S_CARVE;
      ffha_pkg::S_CARVE: state_next = carve_rm ? ffha_pkg::S_SHL_RD : ffha_pkg::S_FIN_WR;
      ffha_pkg::S_FSCAN_RD: state_next = (idx >= ext_count) ? ffha_pkg::S_FDECIDE :
                                         ffha_pkg::S_FSCAN_CHK;
      ffha_pkg::S_FSCAN_CHK: state_next = (e_rdata.start > off) ? ffha_pkg::S_FDECIDE :
                                          ffha_pkg::S_FSCAN_RD;
      ffha_pkg::S_FDECIDE: begin
        if (f_left && f_right) state_next = ffha_pkg::S_SHL_RD;
        else if (f_left || f_right) state_next = ffha_pkg::S_FIN_WR;
        else if (ext_full) state_next = ffha_pkg::S_DONE;
        else state_next = ffha_pkg::S_SHR_RD;
      end
      ffha_pkg::S_SHL_RD: state_next = (sh > ext_count) ? ffha_pkg::S_FIN_WR :
                                       ffha_pkg::S_SHL_WR;
      ffha_pkg::S_SHL_WR: state_next = ffha_pkg::S_SHL_RD;
      ffha_pkg::S_SHR_RD: state_next = (sh == idx) ? ffha_pkg::S_FIN_WR :
                                       ffha_pkg::S_SHR_WR;
      ffha_pkg::S_SHR_WR: state_next = ffha_pkg::S_SHR_RD;
      ffha_pkg::S_FIN_WR: state_next = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE: state_next = ffha_pkg::S_IDLE;
      default: state_next = ffha_pkg::S_IDLE;
    endcase
  end

  // RAM port drivers
  always_comb begin
    e_we = 1'b0; e_addr = idx[ExtAW-1:0]; e_wdata = cur;
    h_we = 1'b0; h_addr = off[OffW-1:GrW]; h_wdata = bytes[SizeW-1:0];
    case (state)
      ffha_pkg::S_CLEAR: begin h_we = 1'b1; h_addr = clr_addr; h_wdata = '0; end
      ffha_pkg::S_LAST_RD: e_addr = ExtAW'(ext_count - CntW'(1));
      ffha_pkg::S_SHL_RD: e_addr = sh[ExtAW-1:0];
      ffha_pkg::S_SHL_WR: begin
        e_we = 1'b1; e_addr = ExtAW'(sh - CntW'(1)); e_wdata = e_rdata;
      end
      ffha_pkg::S_SHR_RD: e_addr = ExtAW'(sh - CntW'(1));
      ffha_pkg::S_SHR_WR: begin e_we = 1'b1; e_addr = sh[ExtAW-1:0]; e_wdata = e_rdata; end
      ffha_pkg::S_FIN_WR: begin
        e_we = ext_wr;
        h_we = 1'b1;
        h_wdata = (op == ffha_pkg::OP_FREE) ? '0 : bytes[SizeW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffha_pkg::S_CLEAR;
      clr_addr <= '0;
      heap_base <= '0;
      page_limit <= 9'd256;
      ext_count <= '0;
      pages_held <= PageW'(1);
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == 1'b0) heap_base <= cfg_data;
        else page_limit <= cfg_data[8:0];
      end
      if (state == ffha_pkg::S_DONE) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ffha_pkg::S_CLEAR: clr_addr <= clr_addr + HdrAW'(1);
        ffha_pkg::S_IDLE: if (s_tvalid && s_tready) begin
          op <= s_tdata[0];
          bytes <= req_round;
          off <= foff64[OffW-1:0];
          bad_range <= (foff64 >= 64'(ffha_pkg::HeapBytes)) || (foff64[GrW-1:0] != '0);
          idx <= '0;
          res_status <= ffha_pkg::ST_OK;
          res_addr <= '0;
          lft_valid <= 1'b0;
        end
        ffha_pkg::S_HDR_RD: if (bad_range) res_status <= ffha_pkg::ST_BADFREE;
        ffha_pkg::S_HDR_CHK: begin
          fsize <= h_rdata;
          if (h_rdata == '0) res_status <= ffha_pkg::ST_BADFREE;
        end
        ffha_pkg::S_SCAN_CHK: begin
          cur <= e_rdata;
          if (!fit) idx <= idx + CntW'(1);
        end
        ffha_pkg::S_LAST_CHK: begin
          cur <= e_rdata;
          grew_merge <= (ext_count != '0) && (cur_end == (SizeW+1)'(nstart));
        end
        ffha_pkg::S_GROW: begin
          if (grow_nomem) begin
            res_status <= ffha_pkg::ST_NOMEM;
          end else if (!grew_merge && ext_full) begin
            res_status <= ffha_pkg::ST_FULL;
          end else begin
            pages_held <= pages_held + grow_n[PageW-1:0];
            if (grew_merge) begin
              idx <= ext_count - CntW'(1);
              cur.size <= cur.size + grow_bytes;
            end else begin
              // new extent is written at the final step
              idx <= ext_count;
              ext_count <= ext_count + CntW'(1);
              cur.start <= nstart[OffW-1:0];
              cur.size <= grow_bytes;
            end
          end
        end
        ffha_pkg::S_CARVE: begin
          off <= carve_off;
          res_addr <= heap_base + 64'(carve_off) + 64'd8;
          if (carve_rm) begin
            // drop entry idx: move idx+1.. down by one
            ext_wr <= 1'b0;
            ext_count <= ext_count - CntW'(1);
            sh <= idx + CntW'(1);
          end else begin
            ext_wr <= 1'b1;
            cur.size <= cur_left;
          end
        end
        ffha_pkg::S_FSCAN_CHK: if (e_rdata.start <= off) begin
          lft <= e_rdata; lft_valid <= 1'b1; idx <= idx + CntW'(1);
        end else begin
          cur <= e_rdata;
        end
        ffha_pkg::S_FDECIDE: begin
          ext_wr <= 1'b1;
          if (f_left && f_right) begin
            cur.start <= lft.start;
            cur.size <= lft.size + fsize + cur.size;
            ext_count <= ext_count - CntW'(1);
            sh <= idx + CntW'(1);
            idx <= idx - CntW'(1);
          end else if (f_left) begin
            cur.start <= lft.start;
            cur.size <= lft.size + fsize;
            idx <= idx - CntW'(1);
          end else if (f_right) begin
            cur.start <= off;
            cur.size <= cur.size + fsize;
          end else if (ext_full) begin
            res_status <= ffha_pkg::ST_FULL;
          end else begin
            // open a slot at idx: move idx.. up by one from the top
            cur.start <= off;
            cur.size <= fsize;
            sh <= ext_count;
            ext_count <= ext_count + CntW'(1);
          end
        end
        ffha_pkg::S_SHL_WR: sh <= sh + CntW'(1);
        ffha_pkg::S_SHR_WR: sh <= sh - CntW'(1);
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid)
    else $error("result raised at accept");
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    ext_count <= CntW'(ffha_pkg::MaxExtents))
    else $error("extent count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (pages_held != $past(pages_held)) |-> (9'(pages_held) <= lim || $past(cfg_valid)))
    else $error("heap grew past limit");
endmodule
